// ===== rtl/phlpm_pkg.sv =====
// Shared types and constants for the pulse high/low period meter.
package phlpm_pkg;

  localparam int TIMER_BITS = 16;
  localparam int COUNT_BITS = 16;
  localparam int ELAPSED_W  = 32;
  localparam int TIME_W     = ELAPSED_W - 1;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [DATA_W-1:0] THRESH_RESET = DATA_W'(150000);

  // Word index of the configuration registers.
  localparam logic REG_PERIOD_THRESHOLD = 1'b0;

  typedef enum logic {
    OP_OVERFLOW = 1'b0,
    OP_CAPTURE  = 1'b1
  } opcode_t;

  typedef enum logic {
    PHASE_HIGH = 1'b0,
    PHASE_LOW  = 1'b1
  } phase_t;

endpackage

// ===== rtl/pulse_high_low_period_meter.sv =====
// Top level of the pulse high/low period meter with its configuration port.
//
// The meter accepts one item per clock while in_stall is low: timer overflow
// ticks and capture events may arrive on consecutive cycles without a pause.
// An item passes through the input register, and a capture then loads its
// result into the output register once that register is free. Overflow
// ticks only advance the overflow count and give no result. The sustained
// rate is set by the output register alone: while a result waits under
// stall, overflow ticks keep flowing until a capture reaches the input
// register, and that capture then holds the input until the result is
// taken. The period threshold is at byte address 0 and resets to 150000
// microseconds.
module pulse_high_low_period_meter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [phlpm_pkg::ADDR_W-1:0]         paddr,
  input  logic [phlpm_pkg::DATA_W-1:0]         pwdata,
  output logic [phlpm_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic [phlpm_pkg::TIMER_BITS-1:0]     capture_stamp,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [phlpm_pkg::TIME_W-1:0]         high_time,
  output logic [phlpm_pkg::TIME_W-1:0]         low_time,
  output logic [phlpm_pkg::ELAPSED_W-1:0]      total_time,
  output logic                                 over_limit,
  output logic                                 measured_phase
);
  import phlpm_pkg::*;

  logic [DATA_W-1:0]     period_threshold;
  logic [TIMER_BITS-1:0] previous_stamp;
  logic [COUNT_BITS-1:0] overflow_count;
  logic                  rising_edge_next;

  logic                  s1_valid;
  opcode_t               s1_opcode;
  logic [TIMER_BITS-1:0] s1_stamp;

  logic                  out_free;
  logic                  s1_advance;
  logic                  s1_capture;
  logic                  out_load;
  logic [ELAPSED_W-1:0]  elapsed;
  logic [TIME_W-1:0]     micros;
  logic [TIME_W-1:0]     high_next;
  logic [TIME_W-1:0]     low_next;
  logic [ELAPSED_W-1:0]  total_next;
  logic                  cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_PERIOD_THRESHOLD);
  assign prdata    = (paddr[ADDR_W-1] == REG_PERIOD_THRESHOLD) ? period_threshold : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_threshold <= THRESH_RESET;
    end else if (cfg_write) begin
      period_threshold <= pwdata;
    end
  end

  assign out_free   = !out_valid || !out_stall;
  assign s1_capture = s1_valid && (s1_opcode == OP_CAPTURE);
  // Overflow ticks never need the output register, so they never wait.
  assign s1_advance = s1_valid && ((s1_opcode == OP_OVERFLOW) || out_free);
  assign out_load   = s1_capture && out_free;
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_opcode <= opcode_t'(opcode);
      s1_stamp  <= capture_stamp;
    end
  end

  // Elapsed clocks wrap at 32 bits before halving.
  assign elapsed    = ELAPSED_W'({overflow_count, s1_stamp}) - ELAPSED_W'(previous_stamp);
  assign micros     = elapsed[ELAPSED_W-1:1];
  assign high_next  = rising_edge_next ? high_time : micros;
  assign low_next   = rising_edge_next ? micros : low_time;
  assign total_next = ELAPSED_W'(high_next) + ELAPSED_W'(low_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_stamp   <= '0;
      overflow_count   <= '0;
      rising_edge_next <= 1'b0;
    end else if (s1_advance) begin
      if (s1_opcode == OP_OVERFLOW) begin
        overflow_count <= overflow_count + 1'b1;
      end else begin
        overflow_count   <= '0;
        previous_stamp   <= s1_stamp;
        rising_edge_next <= !rising_edge_next;
      end
    end
  end

  // The output registers double as the held high and low times.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      high_time      <= '0;
      low_time       <= '0;
      total_time     <= '0;
      over_limit     <= 1'b0;
      measured_phase <= PHASE_HIGH;
    end else begin
      if (out_load) begin
        out_valid      <= 1'b1;
        high_time      <= high_next;
        low_time       <= low_next;
        total_time     <= total_next;
        over_limit     <= total_next > period_threshold;
        measured_phase <= rising_edge_next ? PHASE_LOW : PHASE_HIGH;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/phlpm_checker.sv =====
// Port-level checks for the pulse high/low period meter, bound to the top level.
module phlpm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [phlpm_pkg::TIME_W-1:0]    high_time,
  input logic [phlpm_pkg::TIME_W-1:0]    low_time,
  input logic [phlpm_pkg::ELAPSED_W-1:0] total_time,
  input logic                            measured_phase
);
  import phlpm_pkg::*;

  // A result waiting under stall keeps its high time, low time and measured phase.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(high_time) && $stable(low_time)
      && $stable(measured_phase))
    else $error("result changed while stalled");

  // The total of a valid result is the wrapped sum of the two phase times.
  a_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> total_time == (ELAPSED_W'(high_time) + ELAPSED_W'(low_time)))
    else $error("total_time is not high_time plus low_time");

  // Back-to-back results alternate between high and low phase.
  a_alt: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall ##1 out_valid |-> measured_phase != $past(measured_phase))
    else $error("measured phase did not alternate");

  // A low-phase result leaves the previous high time in place.
  a_keep_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall ##1 out_valid && (measured_phase == PHASE_LOW)
      |-> high_time == $past(high_time))
    else $error("high_time changed on a low-phase result");

endmodule

bind pulse_high_low_period_meter phlpm_checker u_phlpm_checker (.*);
